// ===== hdl/utf8_to_utf32_stream_decoder_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the UTF-8 to UTF-32 stream decoder
// Concurrent checks sampled on the rising clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF32_STREAM_DECODER_UNIT_MACROS_SVH
`define UTF8_TO_UTF32_STREAM_DECODER_UNIT_MACROS_SVH

// Same-cycle implication
`define U8DEC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8dec assertion failed");

// Next-cycle implication
`define U8DEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8dec assertion failed");

`endif

// ===== hdl/u8dec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dec_pkg
// Types and byte classification constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

    localparam int CP_W = 21;

    // Lead byte classes: (byte & MASK) == CODE
    localparam logic [7:0] ASCII_MASK = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    // Payload bits kept from lead and following bytes
    localparam logic [7:0] LEAD2_BITS = 8'h1F;
    localparam logic [7:0] LEAD3_BITS = 8'h0F;
    localparam logic [7:0] LEAD4_BITS = 8'h07;
    localparam logic [7:0] CONT_BITS  = 8'h3F;

    // Following bytes expected after each lead class
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_ONE   = 2'd1;
    localparam logic [1:0] PEND_TWO   = 2'd2;
    localparam logic [1:0] PEND_THREE = 2'd3;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            final_code;
    } result_t;

endpackage

// ===== hdl/u8dec_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dec_step
// Holds the sequence state and decodes one byte per accepted word.
// ----------------------------------------------------------------------------
module u8dec_step
    import u8dec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       final_byte,
    output logic       res_valid,
    output result_t    res
);

    logic [1:0]      pend_reg;
    logic [1:0]      pend_next;
    logic [CP_W-1:0] part_reg;
    logic [CP_W-1:0] part_next;
    logic [1:0]      pend_dec;
    logic [CP_W-1:0] part_shift;
    logic [7:0]      lead_bits;
    logic [1:0]      lead_pend;
    logic            lead_ok;
    logic [CP_W-1:0] lead_val;

    // Shift in six bits of a following byte
    assign pend_dec   = pend_reg - 2'd1;
    assign part_shift = {part_reg[CP_W-7:0], in_byte[5:0] & CONT_BITS[5:0]};
    assign lead_val   = {{(CP_W-8){1'b0}}, in_byte & lead_bits};

    // Classify a lead byte; order matters since the masks nest
    always_comb
    begin
        lead_ok   = 1'b1;
        lead_pend = PEND_NONE;
        lead_bits = 8'h00;
        priority if ((in_byte & LEAD2_MASK) == LEAD2_CODE)
        begin
            lead_pend = PEND_ONE;
            lead_bits = LEAD2_BITS;
        end
        else if ((in_byte & LEAD3_MASK) == LEAD3_CODE)
        begin
            lead_pend = PEND_TWO;
            lead_bits = LEAD3_BITS;
        end
        else if ((in_byte & LEAD4_MASK) == LEAD4_CODE)
        begin
            lead_pend = PEND_THREE;
            lead_bits = LEAD4_BITS;
        end
        else
        begin
            lead_ok = 1'b0;
        end
    end

    // Decide result and next state
    always_comb
    begin
        res_valid      = 1'b0;
        res.code_point = part_shift;
        res.final_code = final_byte;
        pend_next      = PEND_NONE;
        part_next      = '0;
        if (pend_reg != PEND_NONE)
        begin
            if (pend_dec != PEND_NONE && !final_byte)
            begin
                pend_next = pend_dec;
                part_next = part_shift;
            end
            else
            begin
                res_valid = 1'b1;
            end
        end
        else if ((in_byte & ASCII_MASK) == 8'h00)
        begin
            res_valid      = 1'b1;
            res.code_point = {{(CP_W-8){1'b0}}, in_byte};
        end
        else if (!lead_ok)
        begin
            res_valid      = 1'b1;
            res.code_point = REPLACEMENT_CP;
        end
        else if (final_byte)
        begin
            // String ends on a lead byte: emit its payload
            res_valid      = 1'b1;
            res.code_point = lead_val;
        end
        else
        begin
            pend_next = lead_pend;
            part_next = lead_val;
        end
    end

    // Advance state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= PEND_NONE;
            part_reg <= '0;
        end
        else if (accept)
        begin
            pend_reg <= pend_next;
            part_reg <= part_next;
        end
    end

endmodule

// ===== hdl/u8dec_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dec_out_buf
// Result register with one skid entry, so the input side can stall on a registered full flag.
// ----------------------------------------------------------------------------
module u8dec_out_buf
    import u8dec_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    pop;

    assign pop       = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Control: refill from skid first, else take the new word or park it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
    end

endmodule

// ===== hdl/utf8_to_utf32_stream_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf32_stream_decoder_unit
// Decodes a UTF-8 byte stream into UTF-32 code points.
// ----------------------------------------------------------------------------
// Input channel: byte_valid / byte_stall carry in_byte and final_byte; a word
// moves at a clock edge with valid high and stall low. final_byte marks the
// last byte of a string.
// Output channel: code_valid / code_stall carry code_point and final_code.
// A byte completing a character (or an ASCII byte, an invalid lead byte, or
// any final byte) yields one code point; other bytes yield none.
// Throughput: one byte per cycle while byte_stall is low. The code point is
// written to the result register, or parked in the skid entry, as the byte
// that completes it is taken; the decode is a single pass from the sequence
// state register into the result register. When the receiver stalls, one more
// result is parked in the skid entry and byte_stall rises with it; it falls
// once the stall clears. Reset (rst_n low, asynchronous) clears the sequence
// state and empties the result register and skid entry.
// ----------------------------------------------------------------------------
module utf8_to_utf32_stream_decoder_unit
    import u8dec_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_valid,
    output logic            byte_stall,
    input  logic [7:0]      in_byte,
    input  logic            final_byte,
    output logic            code_valid,
    input  logic            code_stall,
    output logic [CP_W-1:0] code_point,
    output logic            final_code
);

    logic    accept;
    logic    res_valid;
    logic    buf_full;
    result_t res;
    result_t out_data;

    // Take a word whenever the skid entry is free
    assign byte_stall = buf_full;
    assign accept     = byte_valid && !buf_full;

    u8dec_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_byte),
        .final_byte (final_byte),
        .res_valid  (res_valid),
        .res        (res)
    );

    u8dec_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (code_valid),
        .out_stall (code_stall),
        .out_data  (out_data)
    );

    assign code_point = out_data.code_point;
    assign final_code = out_data.final_code;

endmodule

// ===== hdl/u8dec_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dec_checker
// Port-level checks for the stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "utf8_to_utf32_stream_decoder_unit_macros.svh"

module u8dec_checker
    import u8dec_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            byte_valid,
    input logic            byte_stall,
    input logic            final_byte,
    input logic            code_valid,
    input logic            code_stall,
    input logic [CP_W-1:0] code_point,
    input logic            final_code
);

    logic          out_busy;
    logic [CP_W:0] out_word;
    logic          final_take;

    // Output word shown but held back, and the whole output word
    assign out_busy   = code_valid && code_stall;
    assign out_word   = {code_point, final_code};
    // Final byte taken while the output is empty
    assign final_take = byte_valid && !byte_stall && final_byte && !code_valid;

    // Hold a stalled output word
    `U8DEC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_busy, code_valid && $stable(out_word))

    // Input stalls only while a result is shown
    `U8DEC_ASSERT_IMPL(a_stall_has_out, clk, rst_n, byte_stall, code_valid)

    // Input stall rises only after an output stall
    `U8DEC_ASSERT_IMPL(a_stall_cause, clk, rst_n, $rose(byte_stall), $past(code_stall))

    // A final byte into an empty output shows a final code point next cycle
    `U8DEC_ASSERT_NEXT(a_final_out, clk, rst_n, final_take, code_valid && final_code)

endmodule

bind utf8_to_utf32_stream_decoder_unit u8dec_checker u_u8dec_checker (.*);
